// File: sv/b64d_pkg.sv
// ============================================================================
// b64d_pkg
// Shared types, character constants and the character classifier for the
// lenient base64 decoder.
// ============================================================================
`default_nettype none

package b64d_pkg;

    // Depth of the queue between the classify stage and the decode stage.
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned ACC_W    = 12;
    localparam int unsigned PEND_W   = 3;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_UNDER   = 8'h5F;
    localparam logic [CHAR_W-1:0] CHAR_PAD     = 8'h3D;

    // Sextet values at the start of each alphabet range.
    localparam logic [SEXTET_W-1:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [SEXTET_W-1:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [SEXTET_W-1:0] SEXTET_62         = 6'd62;
    localparam logic [SEXTET_W-1:0] SEXTET_63         = 6'd63;

    // Pending bit counts held between characters.
    localparam logic [PEND_W-1:0] PEND_0 = 3'd0;
    localparam logic [PEND_W-1:0] PEND_2 = 3'd2;
    localparam logic [PEND_W-1:0] PEND_4 = 3'd4;
    localparam logic [PEND_W-1:0] PEND_6 = 3'd6;

    typedef enum logic [1:0] {
        KIND_SEXTET,
        KIND_PAD,
        KIND_SKIP
    } b64d_kind_t;

    typedef struct packed {
        b64d_kind_t          kind;
        logic [SEXTET_W-1:0] sextet;
        logic                last;
    } b64d_item_t;

    function automatic b64d_item_t b64d_classify(input logic [CHAR_W-1:0] c,
                                                 input logic last);
        b64d_item_t item;
        item.kind   = KIND_SKIP;
        item.sextet = '0;
        item.last   = last;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            item.kind   = KIND_SEXTET;
            item.sextet = SEXTET_W'(c - CHAR_UPPER_A);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            item.kind   = KIND_SEXTET;
            item.sextet = SEXTET_W'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            item.kind   = KIND_SEXTET;
            item.sextet = SEXTET_W'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
        end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            item.kind   = KIND_SEXTET;
            item.sextet = SEXTET_62;
        end else if (c == CHAR_SLASH || c == CHAR_UNDER) begin
            item.kind   = KIND_SEXTET;
            item.sextet = SEXTET_63;
        end else if (c == CHAR_PAD) begin
            item.kind   = KIND_PAD;
        end
        return item;
    endfunction

endpackage

`default_nettype wire

// File: sv/base64_lenient_decoder.sv
// ============================================================================
// base64_lenient_decoder
// Lenient base64 decoder: one character in, at most one byte out per transfer.
// ============================================================================
// Usage:
//   Input channel s_axis_*: one character per transfer in s_axis_tdata, with
//   s_axis_tlast on the final character of a string. Standard and URL-safe
//   alphabets are both decoded; unknown characters are skipped and the first
//   '=' ends decoding for the rest of the string.
//   Output channel m_axis_*: one transfer per decoded byte, m_axis_tlast on
//   the one for the final character (sent with no byte if none); m_axis_tuser
//   flags whether m_axis_tdata carries a byte (it reads zero otherwise).
//   Throughput: one character per cycle while m_axis_tready stays high.
//   Each stage (classify register, queue, decode with output register)
//   handles one item a cycle unless the stage after it is full.
//   Path: the transfer loads the classify register, whose item moves on
//   into a queue entry and then through the decode into the output register.
//   Reset: aresetn low clears the queue, the pending bits, the pad flag and
//   both valid flags; no transfer is to be taken during reset (sender's duty).
//   Stall: when m_axis_tready is low the output register holds, the queue
//   fills, and s_axis_tready falls only once the queue and the classify
//   register are both full.
// ============================================================================
`default_nettype none

module base64_lenient_decoder #(
    parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,    // [7:0] char_code
    input  wire        s_axis_tlast,    // last_char
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic       m_axis_tuser,    // [0] byte_valid
    output logic       m_axis_tlast     // end_of_string
);
    import b64d_pkg::*;

    // Classified items from the front stage into the queue.
    logic       push_valid, push_ready;
    b64d_item_t push_item;
    // Items from the queue into the decode stage.
    logic       pop_valid, pop_ready;
    b64d_item_t pop_item;

    // Accept and classify characters; drop plain skipped ones early.
    b64d_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    // Decouple classify and decode so each side can stall on its own.
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Accumulate sextets, emit bytes and end markers.
    b64d_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A result without a byte exists only to mark the end of a string.
    a_nobyte_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 8'h00))
        else $error("empty result without end of string");

endmodule

`default_nettype wire

// File: sv/b64d_front.sv
// ============================================================================
// b64d_front
// Accept characters, classify them and hold one classified item for the queue.
// ============================================================================
`default_nettype none

module b64d_front (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [7:0]                   s_axis_tdata,   // [7:0] char_code
    input  wire                          s_axis_tlast,   // last_char
    output logic                         push_valid,
    input  wire                          push_ready,
    output b64d_pkg::b64d_item_t         push_item
);
    import b64d_pkg::*;

    logic       valid_reg, valid_next;
    b64d_item_t item_reg, item_next;
    b64d_item_t cls;
    logic       take;

    assign s_axis_tready = !valid_reg || push_ready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign cls           = b64d_classify(s_axis_tdata, s_axis_tlast);

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (valid_reg && push_ready) begin
            valid_next = 1'b0;
        end
        if (take) begin
            // drop skipped characters that do not close the string
            valid_next = !(cls.kind == KIND_SKIP && !cls.last);
            item_next  = cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

`default_nettype wire

// File: sv/b64d_queue.sv
// ============================================================================
// b64d_queue
// Small FIFO of classified items between the classify and decode stages.
// ============================================================================
`default_nettype none

module b64d_queue #(
    parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          push_valid,
    output logic                         push_ready,
    input  wire  b64d_pkg::b64d_item_t   push_item,
    output logic                         pop_valid,
    input  wire                          pop_ready,
    output b64d_pkg::b64d_item_t         pop_item
);
    import b64d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    b64d_item_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

// File: sv/b64d_back.sv
// ============================================================================
// b64d_back
// Gather sextets into bytes and drive the registered result channel.
// ============================================================================
`default_nettype none

module b64d_back (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          pop_valid,
    output logic                         pop_ready,
    input  wire  b64d_pkg::b64d_item_t   pop_item,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // [7:0] out_byte
    output logic                         m_axis_tuser,   // byte_valid
    output logic                         m_axis_tlast    // end_of_string
);
    import b64d_pkg::*;

    logic [ACC_W-1:0]  acc_reg,  acc_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              pad_reg,  pad_next;

    logic              mv_reg, mv_next;
    logic [7:0]        mdata_reg, mdata_next;
    logic              muser_reg, muser_next;
    logic              mlast_reg, mlast_next;

    logic [ACC_W-1:0]  acc_new;
    logic [ACC_W-1:0]  acc_shift;
    logic              have_byte;
    logic              do_pop;

    assign pop_ready = !mv_reg || m_axis_tready;
    assign do_pop    = pop_valid && pop_ready;
    assign acc_new   = {acc_reg[ACC_W-SEXTET_W-1:0], pop_item.sextet};

    always_comb begin
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        pad_next   = pad_reg;
        have_byte  = 1'b0;
        acc_shift  = acc_new;
        mv_next    = mv_reg && !m_axis_tready;
        mdata_next = mdata_reg;
        muser_next = muser_reg;
        mlast_next = mlast_reg;
        if (do_pop) begin
            if (!pad_reg) begin
                if (pop_item.kind == KIND_PAD) begin
                    pad_next = 1'b1;
                end else if (pop_item.kind == KIND_SEXTET) begin
                    acc_next = acc_new;
                    // pending 0 -> 6 bits held; 2/4/6 -> a byte, 0/2/4 left
                    case (pend_reg)
                        PEND_0: begin
                            pend_next = PEND_6;
                        end
                        PEND_2: begin
                            pend_next = PEND_0;
                            have_byte = 1'b1;
                        end
                        PEND_4: begin
                            pend_next = PEND_2;
                            have_byte = 1'b1;
                            acc_shift = acc_new >> 2;
                        end
                        PEND_6: begin
                            pend_next = PEND_4;
                            have_byte = 1'b1;
                            acc_shift = acc_new >> 4;
                        end
                        default: begin
                            pend_next = PEND_0;
                        end
                    endcase
                end
            end
            if (have_byte || pop_item.last) begin
                mv_next    = 1'b1;
                mdata_next = have_byte ? acc_shift[7:0] : 8'h00;
                muser_next = have_byte;
                mlast_next = pop_item.last;
            end
            if (pop_item.last) begin
                acc_next  = '0;
                pend_next = PEND_0;
                pad_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            pend_reg <= PEND_0;
            pad_reg  <= 1'b0;
            mv_reg   <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            pad_reg  <= pad_next;
            mv_reg   <= mv_next;
        end
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
        mlast_reg <= mlast_next;
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tuser  = muser_reg;
    assign m_axis_tlast  = mlast_reg;

    a_pend_even: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == PEND_0 || pend_reg == PEND_2 || pend_reg == PEND_4 ||
        pend_reg == PEND_6)
        else $error("pending bit count out of range");

    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && pop_item.last) |=> (pend_reg == PEND_0 && !pad_reg))
        else $error("state not cleared after last character");

endmodule

`default_nettype wire

// File: verif/tb_base64_lenient_decoder.sv
// ============================================================================
// tb_base64_lenient_decoder
// Self-checking testbench for the lenient base64 decoder. Strings are streamed
// one character per transfer, and each transfer is run through a cycle-free
// decode of the same rules. The expected results are queued and compared field
// by field against every output transfer. Both channels idle at random, and one
// long output stall fills the block until it pushes back on its input.
// ============================================================================

module tb_base64_lenient_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    typedef logic [7:0] char_q_t[$];

    // One output transfer as the decoder should produce it.
    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       eos;
    } decoded_t;

    localparam int unsigned TIMEOUT_NS  = 2_000_000;
    localparam int unsigned DRAIN_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 10;
    localparam int unsigned GAP_MAX     = 14;
    localparam int unsigned STALL_HOLD  = 120;
    localparam int unsigned RANDOM_CHARS = 810;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;     // [7:0] char_code
    logic       s_axis_tlast  = 1'b0;   // last_char
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tuser;           // [0] byte_valid
    logic       m_axis_tlast;           // end_of_string

    // Expected output transfers, oldest first.
    decoded_t decoded_q[$];

    // Decode state mirrored from the block.
    logic [ACC_W-1:0] acc_bits = '0;
    int unsigned      bits_held = 0;
    logic             pad_hit = 1'b0;

    // Idle controls for both channels; rx_hold is the long output stall.
    int unsigned tx_gap_max = 0;
    int unsigned rx_gap_max = 0;
    int unsigned rx_wait    = 0;
    int unsigned rx_hold    = 0;

    int unsigned chars_sent      = 0;
    int unsigned strings_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned error_count     = 0;

    base64_lenient_decoder i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Decode model
    // ------------------------------------------------------------------------

    // Sort a character into sextet, pad or skip; sx carries the 6-bit value.
    function automatic b64d_kind_t char_kind(input logic [7:0] c, output logic [5:0] sx);
        sx = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            sx = 6'(c - CHAR_UPPER_A);
            return KIND_SEXTET;
        end
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            sx = 6'(c - CHAR_LOWER_A + 26);
            return KIND_SEXTET;
        end
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            sx = 6'(c - CHAR_DIGIT_0 + 52);
            return KIND_SEXTET;
        end
        if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            sx = 6'd62;
            return KIND_SEXTET;
        end
        if (c == CHAR_SLASH || c == CHAR_UNDER) begin
            sx = 6'd63;
            return KIND_SEXTET;
        end
        if (c == CHAR_PAD)
            return KIND_PAD;
        return KIND_SKIP;
    endfunction

    // Advance the decode by one accepted character and queue what it yields.
    task automatic decode_char(input logic [7:0] c, input logic last);
        logic [5:0]  sx;
        b64d_kind_t  kind;
        int unsigned n;
        decoded_t    res;
        res = '{data: 8'h00, has_byte: 1'b0, eos: last};
        if (!pad_hit) begin
            kind = char_kind(c, sx);
            if (kind == KIND_PAD) begin
                pad_hit = 1'b1;
            end else if (kind == KIND_SEXTET) begin
                acc_bits = {acc_bits[5:0], sx};
                n = bits_held + 6;
                if (n >= 8) begin
                    // Top eight of the pending bits form the byte.
                    n -= 8;
                    res.data     = 8'(acc_bits >> n);
                    res.has_byte = 1'b1;
                end
                bits_held = n;
            end
        end
        if (res.has_byte || last)
            decoded_q.push_back(res);
        if (last) begin
            // Drop leftover bits; the next string starts clean.
            acc_bits  = '0;
            bits_held = 0;
            pad_hit   = 1'b0;
        end
    endtask

    // Pick a character for a sextet, using either alphabet for 62 and 63.
    function automatic logic [7:0] sextet_char(input int unsigned v);
        if (v < 26) return 8'(CHAR_UPPER_A + v);
        if (v < 52) return 8'(CHAR_LOWER_A + v - 26);
        if (v < 62) return 8'(CHAR_DIGIT_0 + v - 52);
        if (v == 62) return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
        return $urandom_range(0, 1) ? CHAR_SLASH : CHAR_UNDER;
    endfunction

    function automatic char_q_t text_of(input string s);
        char_q_t txt;
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
        return txt;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one character after a random gap; hold it until the transfer.
    task automatic send_char(input logic [7:0] c, input logic last);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        decode_char(c, last);
        chars_sent++;
        if (last)
            strings_sent++;
    endtask

    task automatic send_text(input char_q_t txt);
        foreach (txt[i])
            send_char(txt[i], i == txt.size() - 1);
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("[%0t] MISMATCH at result %0d: %s expected %0h got %0h",
                 $realtime, results_checked, what, want, got);
        error_count++;
    endtask

    // Drop tready for a random wait after each transfer, or for the long hold.
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end else if (rx_wait > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare every output transfer with the oldest expectation.
    always @(posedge aclk) begin
        decoded_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("unexpected result, tdata", 0, m_axis_tdata);
            end else begin
                want = decoded_q.pop_front();
                if (m_axis_tdata !== want.data)
                    report_mismatch("tdata (out_byte)", want.data, m_axis_tdata);
                if (m_axis_tuser !== want.has_byte)
                    report_mismatch("tuser (byte_valid)", want.has_byte, m_axis_tuser);
                if (m_axis_tlast !== want.eos)
                    report_mismatch("tlast (end_of_string)", want.eos, m_axis_tlast);
            end
            results_checked++;
            rx_wait = $urandom_range(0, rx_gap_max);
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Range edges of both alphabets, both spellings of 62 and 63, and a short
    // string that ends with one byte and bits left over.
    task automatic test_alphabet_edges();
        tx_gap_max = 0;
        rx_gap_max = 0;
        send_text(text_of("AZaz"));
        send_text(text_of("09+/"));
        send_text(text_of("-_"));
    endtask

    // First '=' stops decoding: trailing letters are ignored, and a string of
    // a lone '=' still ends with a flagged empty result.
    task automatic test_padding();
        tx_gap_max = 3;
        rx_gap_max = 3;
        send_text(text_of("TQ==Zm"));
        send_text(text_of("="));
    endtask

    // Bytes outside the alphabets are skipped, including on the last character.
    task automatic test_skipped_chars();
        char_q_t txt;
        // NUL, 'Q', 0xFF, 'U', space, 'J', 0x80
        txt = '{8'h00, 8'h51, 8'hFF, 8'h55, 8'h20, 8'h4A, 8'h80};
        send_text(txt);
    endtask

    // Stall the output long enough for the block to fill and stall its input,
    // while the sender keeps offering back to back.
    task automatic test_output_stall();
        char_q_t txt;
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold    = STALL_HOLD;
        for (int s = 0; s < 8; s++) begin
            txt = {};
            for (int k = 0; k < 8; k++)
                txt.push_back(sextet_char($urandom_range(0, 63)));
            send_text(txt);
        end
    endtask

    // Mostly well-formed strings with random content, padding and stray bytes;
    // some are cut short, some are pure noise. Idle mix changes per phase.
    task automatic test_random_text();
        char_q_t     txt;
        int unsigned target;
        int unsigned groups;
        int unsigned npad;
        int unsigned phase;
        target = chars_sent + RANDOM_CHARS;
        phase  = 0;
        while (chars_sent < target) begin
            case (phase % 5)
                0: begin tx_gap_max = 0;       rx_gap_max = 0;       end
                1: begin tx_gap_max = GAP_MAX; rx_gap_max = 0;       end
                2: begin tx_gap_max = 0;       rx_gap_max = GAP_MAX; end
                3: begin tx_gap_max = GAP_MAX; rx_gap_max = GAP_MAX; end
                default: begin tx_gap_max = 2; rx_gap_max = 2;       end
            endcase
            repeat (12) begin
                if (chars_sent >= target)
                    break;
                txt = {};
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 6))
                        txt.push_back(8'($urandom_range(0, 255)));
                end else begin
                    groups = $urandom_range(1, 4);
                    npad   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
                    for (int g = 0; g < groups; g++) begin
                        for (int k = 0; k < 4; k++) begin
                            if ($urandom_range(0, 7) == 0)
                                txt.push_back(8'($urandom_range(0, 255)));
                            if (g == groups - 1 && k >= 4 - npad)
                                txt.push_back(CHAR_PAD);
                            else
                                txt.push_back(sextet_char($urandom_range(0, 63)));
                        end
                    end
                    // Junk after the padding, or a string cut short.
                    if (npad > 0 && $urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 3))
                            txt.push_back(sextet_char($urandom_range(0, 63)));
                    if ($urandom_range(0, 5) == 0)
                        repeat ($urandom_range(1, 3))
                            if (txt.size() > 1)
                                void'(txt.pop_back());
                end
                send_text(txt);
            end
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        int unsigned drain;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_alphabet_edges();
        test_padding();
        test_skipped_chars();
        test_output_stall();
        test_random_text();

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;

        // Let the queued results come out, then allow for the pipeline depth.
        drain = 0;
        while (decoded_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (decoded_q.size() != 0)
            report_mismatch("results never delivered, count", 0, decoded_q.size());

        $display("Decoded %0d strings (%0d characters), checked %0d output transfers",
                 strings_sent, chars_sent, results_checked);
        $display("Covered both alphabets, skipped bytes, padding cutoff, random idling",
                 " and a long output stall");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout after %0d ns", TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: base64_lenient_decoder.f
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_lenient_decoder.sv
verif/tb_base64_lenient_decoder.sv
